// ===== design/mse_pkg.sv =====
// Shared types, opcode constants and register reset values for the MIPS subset execute block.
`default_nettype none

package mse_pkg;

	localparam logic [31:0] HALT_PC  = 32'hffff_ffff;
	localparam logic [31:0] SP_RESET = 32'h0100_0000;

	localparam logic [4:0] REG_ZERO = 5'd0;
	localparam logic [4:0] REG_V0   = 5'd2;
	localparam logic [4:0] REG_SP   = 5'd29;
	localparam logic [4:0] REG_RA   = 5'd31;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2b;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_wr_t;

	function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			REG_SP: v = SP_RESET;
			REG_RA: v = HALT_PC;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== design/mse_regfile.sv =====
// Register file memory with per-entry valid bits, reset values and write forwarding.
`default_nettype none

module mse_regfile
	import mse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rd_en,
	input  wire logic [4:0]  ra,
	input  wire logic [4:0]  rb,
	input  wire rf_wr_t      wr,
	output logic      [31:0] rda,
	output logic      [31:0] rdb
);

	logic [31:0] mem [32];
	logic [31:0] rdat_a_q, rdat_b_q;
	logic [31:0] fwd_a_q, fwd_b_q;
	logic [4:0]  ra_q, rb_q;
	logic [31:0] vld_q;
	logic        vld_a_q, vld_b_q;
	logic        hit_a_q, hit_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rdat_a_q <= mem[ra];
			rdat_b_q <= mem[rb];
			fwd_a_q  <= wr.data;
			fwd_b_q  <= wr.data;
			ra_q     <= ra;
			rb_q     <= rb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[ra];
				vld_b_q <= vld_q[rb];
				hit_a_q <= wr.en && (wr.idx == ra);
				hit_b_q <= wr.en && (wr.idx == rb);
			end
		end
	end

	assign rda = hit_a_q ? fwd_a_q : (vld_a_q ? rdat_a_q : rf_reset_val(ra_q));
	assign rdb = hit_b_q ? fwd_b_q : (vld_b_q ? rdat_b_q : rf_reset_val(rb_q));

endmodule

`default_nettype wire

// ===== design/mse_dmem.sv =====
// Word-wide data memory with one write port and one registered read port.
`default_nettype none

module mse_dmem #(
	parameter int unsigned DATA_WORDS = 16384,
	localparam int unsigned AW = $clog2(DATA_WORDS)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [31:0]   rdata
);

	logic [31:0] mem [DATA_WORDS];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/mse_addr_mod.sv =====
// Reduces a word address modulo the data memory depth, iteratively when the depth is not a power of two.
`default_nettype none

module mse_addr_mod #(
	parameter int unsigned DATA_WORDS = 16384,
	localparam int unsigned AW = $clog2(DATA_WORDS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req,
	input  wire logic          take,
	input  wire logic [29:0]   word,
	output logic               ack,
	output logic      [AW-1:0] idx
);

	localparam bit POW2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			assign ack = req;
			assign idx = word[AW-1:0];
		end else begin : g_iter
			localparam int unsigned NSTEPS = 31 - AW;
			localparam int unsigned NCYC   = (NSTEPS + 3) / 4;
			localparam int unsigned CW     = $clog2(NCYC + 1);
			localparam int unsigned DVW    = 34;
			localparam logic [DVW-1:0] DV_INIT = DVW'(DATA_WORDS) << (NCYC * 4 - 1);

			typedef enum logic [2:0] {
				AM_IDLE = 3'b001,
				AM_RUN  = 3'b010,
				AM_HOLD = 3'b100
			} am_state_t;

			am_state_t      state_q;
			logic [29:0]    rem_q;
			logic [DVW-1:0] dv_q;
			logic [CW-1:0]  cnt_q;
			logic [DVW-1:0] r_nxt;
			logic [DVW-1:0] d_nxt;

			always_comb begin
				r_nxt = {{(DVW - 30){1'b0}}, rem_q};
				d_nxt = dv_q;
				for (int j = 0; j < 4; j++) begin
					if (r_nxt >= d_nxt) begin
						r_nxt = r_nxt - d_nxt;
					end
					d_nxt = d_nxt >> 1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					state_q <= AM_IDLE;
					cnt_q   <= '0;
				end else begin
					case (state_q)
						AM_IDLE: begin
							if (req) begin
								state_q <= AM_RUN;
								cnt_q   <= CW'(NCYC);
							end
						end
						AM_RUN: begin
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == CW'(1)) begin
								state_q <= AM_HOLD;
							end
						end
						AM_HOLD: begin
							if (take) begin
								state_q <= AM_IDLE;
							end
						end
						default: state_q <= AM_IDLE;
					endcase
				end
			end

			always_ff @(posedge clk) begin
				if (state_q == AM_IDLE) begin
					rem_q <= word;
					dv_q  <= DV_INIT;
				end else if (state_q == AM_RUN) begin
					rem_q <= r_nxt[29:0];
					dv_q  <= d_nxt;
				end
			end

			assign ack = (state_q == AM_HOLD);
			assign idx = rem_q[AW-1:0];
		end
	endgenerate

endmodule

`default_nettype wire

// ===== design/mips_subset_instruction_execute.sv =====
// Top level of the MIPS subset execute block: decode, execute, memory access and result register.
// Non-memory instructions and sw go from the execute stage into the result register; lw goes through
// the execute stage, the registered data memory read and the load stage. When DATA_WORDS is not a power
// of two, lw and sw also wait for the word index reduction. Throughput is one instruction per cycle while
// the output is not stalled; lw stalls the input until it moves on to the load stage.
// Reset clears pc and counters; registers read their reset values through valid bits,
// and memory is not cleared.
`default_nettype none

module mips_subset_instruction_execute
	import mse_pkg::*;
#(
	parameter int unsigned DATA_WORDS = 16384
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instruction_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] next_pc,
	output logic             halted,
	output logic             reg_write,
	output logic      [4:0]  reg_index,
	output logic      [31:0] reg_value,
	output logic             mem_write,
	output logic      [31:0] return_value,
	output logic      [31:0] retired_count
);

	localparam int unsigned AW = $clog2(DATA_WORDS);

	logic        valid_s1, valid_s2;
	logic [31:0] ins_s1;
	logic [4:0]  rt_s2;
	logic [31:0] pc_q, exec_q, r2_q;

	logic        out_valid_q, halted_q, reg_write_q, mem_write_q;
	logic [31:0] next_pc_q, reg_value_q, return_value_q, retired_count_q;
	logic [4:0]  reg_index_q;

	logic [31:0] a, b;
	logic        accept, out_free, active, is_mem, is_lw, is_sw;
	logic        s1_done, s1_to_s2, s2_done, mod_ack, mod_take;
	logic [AW-1:0] mem_idx;
	logic [31:0] dm_rdata;
	rf_wr_t      wb;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sh;
	logic [31:0] imm, pc4, ea, nxt, val;
	logic [4:0]  dst;
	logic        wr, wr_eff;

	always_comb begin
		op     = ins_s1[31:26];
		rs     = ins_s1[25:21];
		rt     = ins_s1[20:16];
		rd     = ins_s1[15:11];
		sh     = ins_s1[10:6];
		fn     = ins_s1[5:0];
		imm    = {{16{ins_s1[15]}}, ins_s1[15:0]};
		pc4    = pc_q + 32'd4;
		ea     = a + imm;
		active = (pc_q != HALT_PC);
		wr     = 1'b0;
		dst    = REG_ZERO;
		val    = 32'd0;
		nxt    = pc4;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin wr = 1'b1; dst = rd; val = b << sh; end
					FN_SRL: begin wr = 1'b1; dst = rd; val = b >> sh; end
					FN_JR: nxt = a;
					FN_ADD, FN_ADDU: begin wr = 1'b1; dst = rd; val = a + b; end
					FN_SUB, FN_SUBU: begin wr = 1'b1; dst = rd; val = a - b; end
					FN_AND: begin wr = 1'b1; dst = rd; val = a & b; end
					FN_OR: begin wr = 1'b1; dst = rd; val = a | b; end
					FN_NOR: begin wr = 1'b1; dst = rd; val = ~(a | b); end
					FN_SLT: begin
						wr = 1'b1; dst = rd; val = {31'd0, $signed(a) < $signed(b)};
					end
					FN_SLTU: begin wr = 1'b1; dst = rd; val = {31'd0, a < b}; end
					default: wr = 1'b0;
				endcase
			end
			OP_J: nxt = {pc4[31:28], ins_s1[25:0], 2'b00};
			OP_JAL: begin
				wr = 1'b1; dst = REG_RA; val = pc_q + 32'd8;
				nxt = {pc4[31:28], ins_s1[25:0], 2'b00};
			end
			OP_BEQ: begin
				if (a == b) begin
					nxt = pc4 + {imm[29:0], 2'b00};
				end
			end
			OP_BNE: begin
				if (a != b) begin
					nxt = pc4 + {imm[29:0], 2'b00};
				end
			end
			OP_ADDIU: begin wr = 1'b1; dst = rt; val = ea; end
			OP_SLTI: begin
				wr = 1'b1; dst = rt; val = {31'd0, $signed(a) < $signed(imm)};
			end
			OP_SLTIU: begin wr = 1'b1; dst = rt; val = {31'd0, a < imm}; end
			OP_ORI: begin wr = 1'b1; dst = rt; val = a | {16'd0, ins_s1[15:0]}; end
			OP_LUI: begin wr = 1'b1; dst = rt; val = {ins_s1[15:0], 16'd0}; end
			default: wr = 1'b0;
		endcase
		if (!active) begin
			nxt = HALT_PC;
		end
		wr_eff = active && wr && (dst != REG_ZERO);
		is_lw  = active && (op == OP_LW);
		is_sw  = active && (op == OP_SW);
		is_mem = is_lw || is_sw;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign s1_done  = valid_s1 && !is_lw && (!is_mem || mod_ack) && out_free;
	assign s1_to_s2 = valid_s1 && is_lw && mod_ack;
	assign s2_done  = valid_s2 && out_free;
	assign in_stall = (valid_s1 && !s1_done) || (valid_s2 && !s2_done);
	assign accept   = in_valid && !in_stall;
	assign mod_take = (s1_done && is_mem) || s1_to_s2;

	always_comb begin
		wb = '0;
		if (s1_done && wr_eff) begin
			wb.en   = 1'b1;
			wb.idx  = dst;
			wb.data = val;
		end else if (s2_done && (rt_s2 != REG_ZERO)) begin
			wb.en   = 1'b1;
			wb.idx  = rt_s2;
			wb.data = dm_rdata;
		end
	end

	mse_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra     (instruction_word[25:21]),
		.rb     (instruction_word[20:16]),
		.wr     (wb),
		.rda    (a),
		.rdb    (b)
	);

	mse_addr_mod #(.DATA_WORDS(DATA_WORDS)) u_addr_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (valid_s1 && is_mem),
		.take   (mod_take),
		.word   (ea[31:2]),
		.ack    (mod_ack),
		.idx    (mem_idx)
	);

	mse_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
		.clk    (clk),
		.we     (s1_done && is_sw),
		.waddr  (mem_idx),
		.wdata  (b),
		.re     (s1_to_s2),
		.raddr  (mem_idx),
		.rdata  (dm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			pc_q        <= 32'd0;
			exec_q      <= 32'd0;
			r2_q        <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_done || s1_to_s2) begin
				valid_s1 <= 1'b0;
			end
			if (s1_to_s2) begin
				valid_s2 <= 1'b1;
			end else if (s2_done) begin
				valid_s2 <= 1'b0;
			end
			if (s1_done || s1_to_s2) begin
				pc_q <= nxt;
				if (active) begin
					exec_q <= exec_q + 32'd1;
				end
			end
			if (wb.en && (wb.idx == REG_V0)) begin
				r2_q <= wb.data;
			end
			if (s1_done || s2_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= instruction_word;
		end
		if (s1_to_s2) begin
			rt_s2 <= rt;
		end
		if (s1_done) begin
			next_pc_q       <= nxt;
			halted_q        <= (nxt == HALT_PC);
			reg_write_q     <= wr_eff;
			reg_index_q     <= wr_eff ? dst : REG_ZERO;
			reg_value_q     <= wr_eff ? val : 32'd0;
			mem_write_q     <= is_sw;
			return_value_q  <= (wr_eff && (dst == REG_V0)) ? val : r2_q;
			retired_count_q <= active ? exec_q + 32'd1 : exec_q;
		end else if (s2_done) begin
			next_pc_q       <= pc_q;
			halted_q        <= (pc_q == HALT_PC);
			reg_write_q     <= (rt_s2 != REG_ZERO);
			reg_index_q     <= rt_s2;
			reg_value_q     <= (rt_s2 != REG_ZERO) ? dm_rdata : 32'd0;
			mem_write_q     <= 1'b0;
			return_value_q  <= (rt_s2 == REG_V0) ? dm_rdata : r2_q;
			retired_count_q <= exec_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign next_pc       = next_pc_q;
	assign halted        = halted_q;
	assign reg_write     = reg_write_q;
	assign reg_index     = reg_index_q;
	assign reg_value     = reg_value_q;
	assign mem_write     = mem_write_q;
	assign return_value  = return_value_q;
	assign retired_count = retired_count_q;

	a_one_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && valid_s2))
		else $error("Execute and load stages hold instructions at the same time.");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == HALT_PC) |=> (pc_q == HALT_PC))
		else $error("Program counter left the halt value.");

	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wb.en |-> (wb.idx != REG_ZERO))
		else $error("Register zero written.");

	a_take_ack: assert property (@(posedge clk) disable iff (!arst_n)
		mod_take |-> mod_ack)
		else $error("Memory index consumed before it was ready.");

endmodule

`default_nettype wire

// ===== bench/mips_subset_instruction_execute_test.sv =====
// Self-checking testbench for the MIPS subset execute block with a built-in instruction predictor.
module mips_subset_instruction_execute_test
	import mse_pkg::*;
();

	localparam int unsigned DATA_WORDS   = 16384;
	localparam int          RANDOM_ITEMS = 1620;
	localparam int          QUIET_TAIL   = 150;
	localparam int          DRAIN_CYCLES = 20;
	localparam int          CYCLE_LIMIT  = 400000;

	localparam logic [5:0] FN_SYSCALL = 6'h0c;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        halted;
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic        mem_write;
		logic [31:0] return_value;
		logic [31:0] retired_count;
	} retire_t;

	typedef struct packed {
		logic [31:0] word;
		retire_t     res;
	} instr_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] instruction_word;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] next_pc;
	logic        halted;
	logic        reg_write;
	logic [4:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_write;
	logic [31:0] return_value;
	logic [31:0] retired_count;

	logic [31:0] pc_q;
	logic [31:0] gpr [32];
	logic [31:0] data_mem [DATA_WORDS];
	bit          mem_valid [DATA_WORDS];
	logic [31:0] executed_q;
	int unsigned written_words [$];

	instr_item_t instr_queue [$];
	retire_t     retire_queue [$];
	instr_item_t drive_item;

	logic in_taken;
	int   in_gap;
	int   out_gap;
	int   fail_count;
	int   cycle_count;
	int   load_count;
	int   store_count;

	mips_subset_instruction_execute #(
		.DATA_WORDS(DATA_WORDS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction_word(instruction_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_pc(next_pc),
		.halted(halted),
		.reg_write(reg_write),
		.reg_index(reg_index),
		.reg_value(reg_value),
		.mem_write(mem_write),
		.return_value(return_value),
		.retired_count(retired_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] rd, input logic [4:0] sh);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Executes one instruction on the shadow machine and queues it with its expected outcome.
	// Instructions that would halt early or load an unwritten word are refused.
	function automatic bit retire_instruction(input logic [31:0] ins, input bit allow_halt);
		logic [5:0]  op;
		logic [5:0]  fn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sh;
		logic [4:0]  dst;
		logic [31:0] imm;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] jt;
		logic [31:0] nxt;
		logic [31:0] val;
		logic [31:0] addr;
		bit          wr;
		bit          stored;
		bit          loading;
		bit          active;
		int unsigned widx;
		retire_t     res;
		instr_item_t item;

		active = (pc_q != HALT_PC);
		op = ins[31:26];
		rs = ins[25:21];
		rt = ins[20:16];
		rd = ins[15:11];
		sh = ins[10:6];
		fn = ins[5:0];
		imm = {{16{ins[15]}}, ins[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		nxt = pc_q + 32'd4;
		jt = {nxt[31:28], ins[25:0], 2'b00};
		addr = a + imm;
		widx = (addr >> 2) % DATA_WORDS;
		wr = 1'b0;
		stored = 1'b0;
		loading = 1'b0;
		dst = REG_ZERO;
		val = 32'd0;

		if (active) begin
			case (op)
				OP_SPECIAL: begin
					case (fn)
						FN_SLL: begin wr = 1'b1; dst = rd; val = b << sh; end
						FN_SRL: begin wr = 1'b1; dst = rd; val = b >> sh; end
						FN_JR: nxt = a;
						FN_ADD, FN_ADDU: begin wr = 1'b1; dst = rd; val = a + b; end
						FN_SUB, FN_SUBU: begin wr = 1'b1; dst = rd; val = a - b; end
						FN_AND: begin wr = 1'b1; dst = rd; val = a & b; end
						FN_OR: begin wr = 1'b1; dst = rd; val = a | b; end
						FN_NOR: begin wr = 1'b1; dst = rd; val = ~(a | b); end
						FN_SLT: begin
							wr = 1'b1; dst = rd; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
						end
						FN_SLTU: begin wr = 1'b1; dst = rd; val = (a < b) ? 32'd1 : 32'd0; end
						default: ;
					endcase
				end
				OP_J: nxt = jt;
				OP_JAL: begin wr = 1'b1; dst = REG_RA; val = pc_q + 32'd8; nxt = jt; end
				OP_BEQ: if (a == b) nxt = pc_q + 32'd4 + (imm << 2);
				OP_BNE: if (a != b) nxt = pc_q + 32'd4 + (imm << 2);
				OP_ADDIU: begin wr = 1'b1; dst = rt; val = a + imm; end
				OP_SLTI: begin
					wr = 1'b1; dst = rt; val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
				end
				OP_SLTIU: begin wr = 1'b1; dst = rt; val = (a < imm) ? 32'd1 : 32'd0; end
				OP_ORI: begin wr = 1'b1; dst = rt; val = a | {16'd0, ins[15:0]}; end
				OP_LUI: begin wr = 1'b1; dst = rt; val = {ins[15:0], 16'd0}; end
				OP_LW: begin wr = 1'b1; dst = rt; loading = 1'b1; val = data_mem[widx]; end
				OP_SW: stored = 1'b1;
				default: ;
			endcase
			if (wr && dst == REG_ZERO)
				wr = 1'b0;
			if (!wr) begin
				dst = REG_ZERO;
				val = 32'd0;
			end
		end else begin
			nxt = HALT_PC;
		end

		if (active && loading && !mem_valid[widx])
			return 1'b0;
		if (nxt == HALT_PC && !allow_halt)
			return 1'b0;

		if (active) begin
			pc_q = nxt;
			if (wr)
				gpr[dst] = val;
			if (stored) begin
				data_mem[widx] = b;
				if (!mem_valid[widx]) begin
					mem_valid[widx] = 1'b1;
					written_words.push_back(widx);
				end
				store_count++;
			end
			if (loading)
				load_count++;
			executed_q = executed_q + 32'd1;
		end

		res.next_pc = nxt;
		res.halted = (nxt == HALT_PC);
		res.reg_write = wr;
		res.reg_index = dst;
		res.reg_value = val;
		res.mem_write = stored;
		res.return_value = gpr[REG_V0];
		res.retired_count = executed_q;
		item.word = ins;
		item.res = res;
		instr_queue.push_back(item);
		return 1'b1;
	endfunction

	function automatic bit idle_allowed();
		return instr_queue.size() > QUIET_TAIL && ((instr_queue.size() / 200) % 2 == 0);
	endfunction

	task automatic check_field(input string name, input logic [31:0] expv,
			input logic [31:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %h, got %h", name, expv, actv);
			fail_count++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (instr_queue.size() > 0) begin
					if (idle_allowed() && $urandom_range(0, 11) == 0) begin
						in_valid <= 1'b0;
						in_gap <= $urandom_range(0, 12);
					end else begin
						drive_item = instr_queue.pop_front();
						instruction_word <= drive_item.word;
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (out_gap > 0) begin
			out_stall <= 1'b1;
			out_gap <= out_gap - 1;
		end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			out_gap <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		retire_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				retire_queue.push_back(drive_item.res);
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (retire_queue.size() == 0) begin
					$error("result transfer with nothing outstanding, next_pc %h", next_pc);
					fail_count++;
				end else begin
					want = retire_queue.pop_front();
					check_field("next_pc", want.next_pc, next_pc);
					check_field("halted", 32'(want.halted), 32'(halted));
					check_field("reg_write", 32'(want.reg_write), 32'(reg_write));
					check_field("reg_index", 32'(want.reg_index), 32'(reg_index));
					check_field("reg_value", want.reg_value, reg_value);
					check_field("mem_write", 32'(want.mem_write), 32'(mem_write));
					check_field("return_value", want.return_value, return_value);
					check_field("retired_count", want.retired_count, retired_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out with %0d results outstanding.", retire_queue.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [31:0] w;
		logic [31:0] rnd;
		logic [15:0] imm16;
		logic [13:0] hit_idx;
		logic [5:0]  fn;
		logic [5:0]  op;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sh;
		int          k;
		int          issued;

		arst_n = 1'b0;
		in_valid = 1'b0;
		instruction_word = 32'd0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		in_gap = 0;
		out_gap = 0;
		fail_count = 0;
		cycle_count = 0;
		load_count = 0;
		store_count = 0;
		pc_q = 32'd0;
		executed_q = 32'd0;
		for (int i = 0; i < 32; i++)
			gpr[i] = 32'd0;
		gpr[REG_SP] = SP_RESET;
		gpr[REG_RA] = HALT_PC;

		// Directed program: extreme values, every operation, r0 writes, address wrap and no-ops.
		void'(retire_instruction(i_word(OP_LUI, 5'd0, 5'd1, 16'hffff), 1'b0));
		void'(retire_instruction(i_word(OP_ORI, 5'd1, 5'd1, 16'hffff), 1'b0));
		void'(retire_instruction(i_word(OP_ADDIU, 5'd0, REG_V0, 16'h7fff), 1'b0));
		void'(retire_instruction(i_word(OP_ADDIU, 5'd0, 5'd3, 16'h8000), 1'b0));
		void'(retire_instruction(r_word(FN_ADD, 5'd1, 5'd1, 5'd4, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_ADDU, REG_V0, 5'd3, 5'd5, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_SUB, 5'd0, 5'd1, 5'd6, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_SUBU, 5'd3, REG_V0, 5'd7, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_AND, 5'd1, 5'd3, 5'd8, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_OR, REG_V0, 5'd3, 5'd9, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_NOR, 5'd0, 5'd0, 5'd10, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_SLL, 5'd0, 5'd1, 5'd11, 5'd31), 1'b0));
		void'(retire_instruction(r_word(FN_SRL, 5'd0, 5'd1, 5'd12, 5'd31), 1'b0));
		void'(retire_instruction(r_word(FN_SLT, 5'd1, REG_V0, 5'd13, 5'd0), 1'b0));
		void'(retire_instruction(r_word(FN_SLTU, 5'd1, REG_V0, 5'd14, 5'd0), 1'b0));
		void'(retire_instruction(i_word(OP_SLTI, 5'd3, 5'd15, 16'h8001), 1'b0));
		void'(retire_instruction(i_word(OP_SLTIU, 5'd0, 5'd16, 16'hffff), 1'b0));
		void'(retire_instruction(i_word(OP_ADDIU, 5'd1, REG_ZERO, 16'h0005), 1'b0));
		void'(retire_instruction(i_word(OP_SW, REG_SP, 5'd1, 16'h0000), 1'b0));
		void'(retire_instruction(i_word(OP_SW, REG_ZERO, 5'd3, 16'hfffc), 1'b0));
		void'(retire_instruction(i_word(OP_LW, REG_ZERO, 5'd17, 16'hfffc), 1'b0));
		void'(retire_instruction(i_word(OP_LW, REG_SP, 5'd18, 16'h0002), 1'b0));
		void'(retire_instruction(r_word(FN_SYSCALL, 5'd1, 5'd1, 5'd19, 5'd0), 1'b0));
		void'(retire_instruction(32'hffff_ffff, 1'b0));
		void'(retire_instruction(i_word(OP_BEQ, 5'd0, 5'd0, 16'h8000), 1'b0));
		void'(retire_instruction(i_word(OP_BNE, 5'd0, 5'd0, 16'h7fff), 1'b0));
		void'(retire_instruction(i_word(OP_BNE, 5'd1, 5'd0, 16'h0010), 1'b0));
		void'(retire_instruction({OP_J, 26'h3ff_ffff}, 1'b0));
		void'(retire_instruction({OP_JAL, 26'h000_0000}, 1'b0));
		void'(retire_instruction(r_word(FN_JR, 5'd3, 5'd0, 5'd0, 5'd0), 1'b0));

		// Random program: mostly supported instructions, loads aimed at stored words, some noise.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			k = $urandom_range(0, 27);
			rnd = $urandom;
			rs = 5'($urandom_range(0, 31));
			rt = 5'($urandom_range(0, 31));
			rd = 5'($urandom_range(0, 31));
			sh = 5'($urandom_range(0, 31));
			imm16 = rnd[31:16];
			fn = FN_SLL;
			op = OP_LW;
			if (k < 12) begin
				case (k)
					0: fn = FN_SLL;
					1: fn = FN_SRL;
					2: fn = FN_JR;
					3: fn = FN_ADD;
					4: fn = FN_ADDU;
					5: fn = FN_SUB;
					6: fn = FN_SUBU;
					7: fn = FN_AND;
					8: fn = FN_OR;
					9: fn = FN_NOR;
					10: fn = FN_SLT;
					default: fn = FN_SLTU;
				endcase
				w = r_word(fn, rs, rt, rd, sh);
			end else if (k < 26) begin
				case (k)
					12: op = OP_J;
					13: op = OP_JAL;
					14: op = OP_BEQ;
					15: op = OP_BNE;
					16: op = OP_ADDIU;
					17: op = OP_SLTI;
					18: op = OP_SLTIU;
					19: op = OP_ORI;
					20: op = OP_LUI;
					21, 22: op = OP_SW;
					default: op = OP_LW;
				endcase
				if (op == OP_LW && written_words.size() > 0) begin
					hit_idx = 14'(written_words[$urandom_range(0, written_words.size() - 1)]);
					imm16 = {hit_idx, rnd[1:0]} - gpr[rs][15:0];
				end
				if (op == OP_J || op == OP_JAL)
					w = {op, rnd[25:0]};
				else
					w = i_word(op, rs, rt, imm16);
			end else if (k == 26) begin
				w = r_word(rnd[5:0], rs, rt, rd, sh);
			end else begin
				w = rnd;
			end
			if (retire_instruction(w, 1'b0))
				issued++;
		end

		// End the program through the return address, then send a few words that must be ignored.
		while (pc_q != HALT_PC) begin
			void'(retire_instruction(i_word(OP_LUI, REG_ZERO, REG_RA, 16'hffff), 1'b1));
			void'(retire_instruction(i_word(OP_ORI, REG_RA, REG_RA, 16'hffff), 1'b1));
			void'(retire_instruction(r_word(FN_JR, REG_RA, REG_ZERO, REG_ZERO, 5'd0), 1'b1));
		end
		repeat (4)
			void'(retire_instruction($urandom, 1'b1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (instr_queue.size() > 0 || in_valid) @(posedge clk);
		while (retire_queue.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Executed %0d instructions, %0d loads and %0d stores, directed then random,",
			executed_q, load_count, store_count);
		$display("with random idling on both sides, ending in a halt followed by ignored words.");
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/mse_pkg.sv
design/mse_regfile.sv
design/mse_dmem.sv
design/mse_addr_mod.sv
design/mips_subset_instruction_execute.sv
bench/mips_subset_instruction_execute_test.sv
